// ----- sv/pnnu_pkg.sv -----
// shared constants and a helper for the proof-number node update block
`timescale 1ns / 1ps

package pnnu_pkg;

    // value width and saturation ceiling
    localparam int unsigned VAL_W = 24;
    localparam logic [VAL_W-1:0] VMAX = 24'hffffff;

    // field widths
    localparam int unsigned DEP_W = 8;
    localparam int unsigned SQ_W  = 7;

    // beat widths
    localparam int unsigned IN_DATA_W  = 112;
    localparam int unsigned OUT_DATA_W = 96;

    // register and parameter defaults
    localparam logic [DEP_W-1:0] DEPTH_LIMIT_RST = 8'd31;
    localparam int unsigned SQUARES_DEF = 81;

    // add that sticks at the ceiling
    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? VMAX : s[VAL_W-1:0];
    endfunction

endpackage

// ----- sv/proof_number_node_update.sv -----
// proof-number node update: folds child beats into one node result
//
//  channel    | dir | fields (lsb first)
//  -----------+-----+------------------------------------------------------------
//  s_axis     | in  | tdata: depth, proof, disproof, steps, size, drop, square;
//             |     | tuser: has_child; tlast: last child of the node
//  m_axis     | out | tdata: proof, disproof, steps, subtree_size
//  cfg        | in  | i_cfg_data: depth limit
//
// one child beat per cycle while the input stage is not stalled; each beat is
// registered in the input stage (where the per-square best proof is read from
// memory). the node result is registered as the last child leaves that stage.
// the input stage stalls only when it holds a last child while a result is still
// waiting downstream. reset is synchronous; the per-square seen flags are
// cleared by reset and after each node.
`timescale 1ns / 1ps

module proof_number_node_update import pnnu_pkg::*; #(
    parameter int unsigned SQUARES = SQUARES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // node_depth[7:0], child_proof[31:8], child_disproof[55:32], child_steps[79:56],
    // child_size[103:80], is_drop[104], drop_square[111:105]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // has_child[0]
    input  logic [0:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // proof[23:0], disproof[47:24], steps[71:48], subtree_size[95:72]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DEP_W-1:0]      i_cfg_data
);

    localparam int unsigned AW = (SQUARES > 1) ? $clog2(SQUARES) : 1;
    localparam int unsigned CW = (SQ_W > AW) ? SQ_W + 1 : AW + 1;

    // configuration
    logic [DEP_W-1:0] r_depth_limit;

    // input stage
    logic             r_v1;
    logic [DEP_W-1:0] r_dep1;
    logic             r_has1;
    logic [VAL_W-1:0] r_cp1;
    logic [VAL_W-1:0] r_cd1;
    logic [VAL_W-1:0] r_cs1;
    logic [VAL_W-1:0] r_cz1;
    logic             r_drop1;
    logic [SQ_W-1:0]  r_sq1;
    logic             r_last1;
    logic [VAL_W-1:0] r_best1;

    // node accumulators
    logic             r_open;
    logic [DEP_W-1:0] r_dep;
    logic [VAL_W-1:0] r_proof;
    logic [VAL_W-1:0] r_disproof;
    logic [VAL_W-1:0] r_steps;
    logic [VAL_W-1:0] r_size;
    logic [SQUARES-1:0] r_seen;
    logic [VAL_W-1:0] r_best_mem [SQUARES];

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // combinational
    logic             s_accept;
    logic             out_free;
    logic             adv;
    logic [AW-1:0]    rd_idx;
    logic [AW-1:0]    wr_idx;
    logic             in_range;
    logic             seen_hit;
    logic             seen_set;
    logic             mem_we;
    logic             cur_odd;
    logic [DEP_W-1:0] cur_dep;
    logic [VAL_W-1:0] p_cur, d_cur, st_cur, sz_cur;
    logic [VAL_W-1:0] n_proof, n_disproof, n_steps, n_size;
    logic [VAL_W:0]   s1_wide;
    logic [VAL_W-1:0] s1_sat;
    logic [OUT_DATA_W-1:0] n_out_data;

    // handshakes
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_v1 && (!r_last1 || out_free);
    assign s_axis_tready = !r_v1 || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign rd_idx = AW'(s_axis_tdata[111:105]);
    assign wr_idx = AW'(r_sq1);

    // fold one child into the node
    always_comb begin
        cur_dep  = r_open ? r_dep : r_dep1;
        cur_odd  = cur_dep[0];
        in_range = {{(CW-SQ_W){1'b0}}, r_sq1} < CW'(SQUARES);
        seen_hit = in_range && r_seen[wr_idx];
        seen_set = 1'b0;
        mem_we   = 1'b0;

        // start values on the first beat of a node
        if (r_open) begin
            p_cur  = r_proof;
            d_cur  = r_disproof;
            st_cur = r_steps;
            sz_cur = r_size;
        end else if (cur_odd) begin
            p_cur  = '0;
            d_cur  = VMAX;
            st_cur = VAL_W'(1);
            sz_cur = VAL_W'(1);
        end else begin
            p_cur  = VMAX;
            d_cur  = '0;
            st_cur = VMAX;
            sz_cur = VAL_W'(1);
        end

        s1_wide = {1'b0, r_cs1} + (VAL_W+1)'(1);
        s1_sat  = s1_wide[VAL_W] ? VMAX : s1_wide[VAL_W-1:0];

        n_proof    = p_cur;
        n_disproof = d_cur;
        n_steps    = st_cur;
        n_size     = sz_cur;

        if (r_has1) begin
            if (!cur_odd) begin
                // attacker: min proof, summed disproof, min steps
                if (r_cp1 < p_cur) n_proof = r_cp1;
                n_disproof = sat_add(d_cur, r_cd1);
                if (s1_wide < {1'b0, st_cur}) n_steps = s1_wide[VAL_W-1:0];
            end else begin
                // defender: summed proof with per-square drop max, min disproof, max steps
                if (r_drop1 && in_range) begin
                    if (!seen_hit) begin
                        n_proof  = sat_add(p_cur, r_cp1);
                        seen_set = 1'b1;
                        mem_we   = 1'b1;
                    end else if (r_cp1 > r_best1) begin
                        n_proof = sat_add(p_cur, r_cp1 - r_best1);
                        mem_we  = 1'b1;
                    end
                end else begin
                    n_proof = sat_add(p_cur, r_cp1);
                end
                if (r_cd1 < d_cur) n_disproof = r_cd1;
                if (s1_sat > st_cur) n_steps = s1_sat;
            end
            n_size = sat_add(sz_cur, r_cz1);
        end

        // node result
        if (cur_dep >= r_depth_limit) begin
            n_out_data = {VAL_W'(1), VMAX, {VAL_W{1'b0}}, VMAX};
        end else begin
            n_out_data = {n_size, n_steps, n_disproof, n_proof};
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_limit <= DEPTH_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_depth_limit <= i_cfg_data;
        end
    end

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_dep1  <= s_axis_tdata[7:0];
            r_cp1   <= s_axis_tdata[31:8];
            r_cd1   <= s_axis_tdata[55:32];
            r_cs1   <= s_axis_tdata[79:56];
            r_cz1   <= s_axis_tdata[103:80];
            r_drop1 <= s_axis_tdata[104];
            r_sq1   <= s_axis_tdata[111:105];
            r_has1  <= s_axis_tuser[0];
            r_last1 <= s_axis_tlast;
        end
    end

    // per-square best proof memory, read forwarded from a same-cycle write
    always_ff @(posedge i_clk) begin
        if (adv && mem_we) begin
            r_best_mem[wr_idx] <= r_cp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            if (adv && mem_we && (wr_idx == rd_idx)) begin
                r_best1 <= r_cp1;
            end else begin
                r_best1 <= r_best_mem[rd_idx];
            end
        end
    end

    // node state control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_seen <= '0;
        end else if (adv) begin
            if (r_last1) begin
                r_open <= 1'b0;
                r_seen <= '0;
            end else begin
                r_open <= 1'b1;
                if (seen_set) r_seen[wr_idx] <= 1'b1;
            end
        end
    end

    // node accumulators
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dep      <= cur_dep;
            r_proof    <= n_proof;
            r_disproof <= n_disproof;
            r_steps    <= n_steps;
            r_size     <= n_size;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_last1) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_last1) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // a result only follows a last child leaving the input stage
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(adv && r_last1))
        else $error("result without a last child");

    // the input stage stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !s_axis_tready) |-> (r_last1 && r_out_valid && !m_axis_tready))
        else $error("input stage stalled without cause");

    // node state is cleared once a node completes
    a_node_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_last1) |=> (!r_open && (r_seen == '0)))
        else $error("node state not cleared after result");
`endif

endmodule
